[hw/rtl/vertex_rotate_project_unit_defines.svh]
// Assertion macros used by the checker of the vertex unit.
`ifndef VERTEX_ROTATE_PROJECT_UNIT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define VRP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vertex unit check failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define VRP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex unit check failed");

`endif

[hw/rtl/vrp_pkg.sv]
`default_nettype none

package vrp_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 128;

    localparam int COORD_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int DEPTH_W   = 16;
    localparam int Q_FRAC    = 14;

    localparam logic [CFG_IDX_W-1:0] REG_SIN_PITCH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COS_PITCH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_YAW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COS_YAW   = CFG_IDX_W'(3);

    localparam logic signed [CFG_W-1:0] Q_ONE = CFG_W'(1 << Q_FRAC);

    localparam int PROD1_W = 2 * COORD_W;
    localparam int SUM1_W  = PROD1_W + 1;
    localparam int ROT1_W  = SUM1_W - Q_FRAC;
    localparam int PROD2_W = ROT1_W + CFG_W;
    localparam int SUM2_W  = PROD2_W + 1;
    localparam int ROT2_W  = SUM2_W - Q_FRAC;

    // Eye distance of 2.0 in the fixed-point format of the rotated depth.
    localparam int DEPTH_BIAS = 2 << Q_FRAC;
    localparam int DEPTH_MAX  = (1 << (DEPTH_W - 1)) - 1;
    localparam int DEPTH_MIN  = -(1 << (DEPTH_W - 1));

    localparam int COL_SCALE  = SCREEN_WIDTH * 10 / 32;
    localparam int COL_CENTER = SCREEN_WIDTH / 2;
    localparam int COL_LIMIT  = SCREEN_WIDTH - 1;
    localparam int ROW_SCALE  = SCREEN_HEIGHT * 100 / 256;
    localparam int ROW_CENTER = SCREEN_HEIGHT / 2;
    localparam int ROW_LIMIT  = SCREEN_HEIGHT - 1;

    localparam int SCALE_MAX = (COL_SCALE > ROW_SCALE) ? COL_SCALE : ROW_SCALE;
    localparam int DEN_W     = ROT2_W;
    localparam int NUM_W     = ROT2_W - 1 + $clog2(SCALE_MAX + 1);

    localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int QBITS      = $clog2(SCREEN_MAX);

    localparam int PRE_STAGES = 5;
    localparam int DIV_STAGES = QBITS + 1;
    localparam int LAT        = PRE_STAGES + DIV_STAGES;

    typedef struct packed {
        logic [NUM_W-1:0] num_mag;
        logic             num_neg;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic [QBITS-1:0] quot;
        logic             rem_nz;
        logic             sat;
        logic             neg;
    } div_res_t;

    // Turns a saturated floor quotient into a screen coordinate clamped to [0, limit].
    function automatic logic [QBITS-1:0] pixel_clamp(input div_res_t r, input int center,
                                                     input int limit);
        logic [QBITS:0]          mag;
        logic signed [QBITS+2:0] q;
        logic signed [QBITS+2:0] pos;
        mag = r.sat ? {1'b1, QBITS'(0)} : {1'b0, r.quot};
        mag = mag + (QBITS+1)'(r.neg & r.rem_nz);
        q   = $signed((QBITS+3)'(mag));
        if (r.neg)
        begin
            q = -q;
        end
        pos = q + (QBITS+3)'(center);
        if (pos < 0)
        begin
            return '0;
        end
        else if (pos > (QBITS+3)'(limit))
        begin
            return QBITS'(limit);
        end
        return pos[QBITS-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/vrp_div.sv]
`default_nettype none

module vrp_div (
    input  logic              clk,
    input  vrp_pkg::div_req_t req,
    output vrp_pkg::div_res_t res
);
    import vrp_pkg::*;

    localparam int CMP_W = DEN_W + QBITS;

    logic [NUM_W-1:0] rem_reg  [QBITS+1];
    logic [QBITS-1:0] quot_reg [QBITS+1];
    logic [DEN_W-1:0] den_reg  [QBITS];
    logic             neg_reg  [QBITS+1];
    logic             sat_reg  [QBITS+1];

    // A quotient of 2^QBITS or more is only flagged; the caller clamps it.
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= req.num_mag;
        quot_reg[0] <= '0;
        den_reg[0]  <= req.den;
        neg_reg[0]  <= req.num_neg;
        sat_reg[0]  <= (CMP_W'(req.num_mag) >> QBITS) >= CMP_W'(req.den);
    end

    for (genvar j = 0; j < QBITS; j++)
    begin : g_step
        localparam int SH = QBITS - 1 - j;

        logic [CMP_W-1:0] trial;
        logic [CMP_W-1:0] rem_ext;
        logic             take;

        assign trial   = CMP_W'(den_reg[j]) << SH;
        assign rem_ext = CMP_W'(rem_reg[j]);
        assign take    = rem_ext >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= take ? NUM_W'(rem_ext - trial) : rem_reg[j];
            quot_reg[j+1] <= quot_reg[j] | (take ? (QBITS'(1) << SH) : QBITS'(0));
            neg_reg[j+1]  <= neg_reg[j];
            sat_reg[j+1]  <= sat_reg[j];
        end

        if (j + 1 < QBITS)
        begin : g_den
            always_ff @(posedge clk)
            begin
                den_reg[j+1] <= den_reg[j];
            end
        end
    end

    assign res.quot   = quot_reg[QBITS];
    assign res.rem_nz = |rem_reg[QBITS];
    assign res.sat    = sat_reg[QBITS];
    assign res.neg    = neg_reg[QBITS];

endmodule

`default_nettype wire

[hw/rtl/vertex_rotate_project_unit.sv]
// Throughput: one item per cycle; busy stays low, start may be held high.
// The first of four rotation stages loads at the accepting edge; the other three, one
// projection setup stage, a 9-stage restoring divider (saturation check plus one quotient
// bit a stage) and the output register follow it in that order.
// Reset clears the valid pipeline and done, and loads the identity rotation.
`default_nettype none

module vertex_rotate_project_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [vrp_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [vrp_pkg::COORD_W-1:0]    coord_y,
    input  logic signed [vrp_pkg::COORD_W-1:0]    coord_z,
    input  logic                                  cfg_wr_en,
    input  logic        [vrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [vrp_pkg::CFG_W-1:0]      cfg_data,
    output logic                                  done,
    output logic        [vrp_pkg::COL_W-1:0]      pixel_col,
    output logic        [vrp_pkg::ROW_W-1:0]      pixel_row,
    output logic signed [vrp_pkg::DEPTH_W-1:0]    depth
);
    import vrp_pkg::*;

    logic signed [CFG_W-1:0] sin_pitch_reg;
    logic signed [CFG_W-1:0] cos_pitch_reg;
    logic signed [CFG_W-1:0] sin_yaw_reg;
    logic signed [CFG_W-1:0] cos_yaw_reg;

    logic           accept;
    logic [LAT-1:0] valid_reg;
    logic           done_reg;

    logic signed [COORD_W-1:0] x_s1_reg;
    logic signed [PROD1_W-1:0] ycp_reg;
    logic signed [PROD1_W-1:0] zsp_reg;
    logic signed [PROD1_W-1:0] ysp_reg;
    logic signed [PROD1_W-1:0] zcp_reg;

    logic signed [SUM1_W-1:0]  y1_sum;
    logic signed [SUM1_W-1:0]  z1_sum;
    logic signed [COORD_W-1:0] x_s2_reg;
    logic signed [ROT1_W-1:0]  y1_s2_reg;
    logic signed [ROT1_W-1:0]  z1_s2_reg;

    logic signed [PROD2_W-1:0] xcy_reg;
    logic signed [PROD2_W-1:0] z1sy_reg;
    logic signed [PROD2_W-1:0] xsy_reg;
    logic signed [PROD2_W-1:0] z1cy_reg;
    logic signed [ROT1_W-1:0]  y1_s3_reg;

    logic signed [SUM2_W-1:0]  x2_sum;
    logic signed [SUM2_W-1:0]  z2_sum;
    logic signed [ROT2_W-1:0]  x2_s4_reg;
    logic signed [ROT2_W-1:0]  z2_s4_reg;
    logic signed [ROT1_W-1:0]  y1_s4_reg;

    logic signed [ROT2_W:0]    d_sum;
    logic signed [NUM_W:0]     ncol;
    logic signed [NUM_W:0]     nrow;
    logic signed [DEPTH_W-1:0] depth_next;
    div_req_t                  col_req_next;
    div_req_t                  row_req_next;
    div_req_t                  col_req_reg;
    div_req_t                  row_req_reg;
    logic signed [DEPTH_W-1:0] depth_s5_reg;

    logic signed [DEPTH_W-1:0] depth_pipe_reg [DIV_STAGES];

    div_res_t                  col_res;
    div_res_t                  row_res;
    logic [QBITS-1:0]          col_next;
    logic [QBITS-1:0]          row_next;
    logic [COL_W-1:0]          pixel_col_reg;
    logic [ROW_W-1:0]          pixel_row_reg;
    logic signed [DEPTH_W-1:0] depth_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_pitch_reg <= '0;
            cos_pitch_reg <= Q_ONE;
            sin_yaw_reg   <= '0;
            cos_yaw_reg   <= Q_ONE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SIN_PITCH: sin_pitch_reg <= cfg_data;
                REG_COS_PITCH: cos_pitch_reg <= cfg_data;
                REG_SIN_YAW:   sin_yaw_reg   <= cfg_data;
                REG_COS_YAW:   cos_yaw_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], accept};
            done_reg  <= valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        x_s1_reg <= coord_x;
        ycp_reg  <= PROD1_W'(coord_y) * PROD1_W'(cos_pitch_reg);
        zsp_reg  <= PROD1_W'(coord_z) * PROD1_W'(sin_pitch_reg);
        ysp_reg  <= PROD1_W'(coord_y) * PROD1_W'(sin_pitch_reg);
        zcp_reg  <= PROD1_W'(coord_z) * PROD1_W'(cos_pitch_reg);
    end

    assign y1_sum = SUM1_W'(ycp_reg) - SUM1_W'(zsp_reg);
    assign z1_sum = SUM1_W'(ysp_reg) + SUM1_W'(zcp_reg);

    always_ff @(posedge clk)
    begin
        x_s2_reg  <= x_s1_reg;
        y1_s2_reg <= y1_sum[SUM1_W-1:Q_FRAC];
        z1_s2_reg <= z1_sum[SUM1_W-1:Q_FRAC];
    end

    always_ff @(posedge clk)
    begin
        xcy_reg   <= PROD2_W'(x_s2_reg) * PROD2_W'(cos_yaw_reg);
        z1sy_reg  <= PROD2_W'(z1_s2_reg) * PROD2_W'(sin_yaw_reg);
        xsy_reg   <= PROD2_W'(x_s2_reg) * PROD2_W'(sin_yaw_reg);
        z1cy_reg  <= PROD2_W'(z1_s2_reg) * PROD2_W'(cos_yaw_reg);
        y1_s3_reg <= y1_s2_reg;
    end

    assign x2_sum = SUM2_W'(xcy_reg) - SUM2_W'(z1sy_reg);
    assign z2_sum = SUM2_W'(xsy_reg) + SUM2_W'(z1cy_reg);

    always_ff @(posedge clk)
    begin
        x2_s4_reg <= x2_sum[SUM2_W-1:Q_FRAC];
        z2_s4_reg <= z2_sum[SUM2_W-1:Q_FRAC];
        y1_s4_reg <= y1_s3_reg;
    end

    // A vertex at or behind the eye divides by the smallest positive step.
    always_comb
    begin
        d_sum = (ROT2_W+1)'(z2_s4_reg) + (ROT2_W+1)'(DEPTH_BIAS);
        ncol  = (NUM_W+1)'(x2_s4_reg) * (NUM_W+1)'(COL_SCALE);
        nrow  = (NUM_W+1)'(y1_s4_reg) * (NUM_W+1)'(ROW_SCALE);

        col_req_next.den     = (d_sum <= 0) ? DEN_W'(1) : d_sum[DEN_W-1:0];
        col_req_next.num_neg = ncol[NUM_W];
        col_req_next.num_mag = ncol[NUM_W] ? NUM_W'(-ncol) : ncol[NUM_W-1:0];

        row_req_next.den     = col_req_next.den;
        row_req_next.num_neg = !nrow[NUM_W] && (nrow != 0);
        row_req_next.num_mag = nrow[NUM_W] ? NUM_W'(-nrow) : nrow[NUM_W-1:0];

        if (z2_s4_reg > ROT2_W'(DEPTH_MAX))
        begin
            depth_next = DEPTH_W'(DEPTH_MAX);
        end
        else if (z2_s4_reg < ROT2_W'(DEPTH_MIN))
        begin
            depth_next = DEPTH_W'(DEPTH_MIN);
        end
        else
        begin
            depth_next = z2_s4_reg[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        col_req_reg  <= col_req_next;
        row_req_reg  <= row_req_next;
        depth_s5_reg <= depth_next;
    end

    vrp_div u_col_div (
        .clk (clk),
        .req (col_req_reg),
        .res (col_res)
    );

    vrp_div u_row_div (
        .clk (clk),
        .req (row_req_reg),
        .res (row_res)
    );

    always_ff @(posedge clk)
    begin
        depth_pipe_reg[0] <= depth_s5_reg;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            depth_pipe_reg[k] <= depth_pipe_reg[k-1];
        end
    end

    assign col_next = pixel_clamp(col_res, COL_CENTER, COL_LIMIT);
    assign row_next = pixel_clamp(row_res, ROW_CENTER, ROW_LIMIT);

    always_ff @(posedge clk)
    begin
        pixel_col_reg <= col_next[COL_W-1:0];
        pixel_row_reg <= row_next[ROW_W-1:0];
        depth_reg     <= depth_pipe_reg[DIV_STAGES-1];
    end

    assign done      = done_reg;
    assign pixel_col = pixel_col_reg;
    assign pixel_row = pixel_row_reg;
    assign depth     = depth_reg;

endmodule

`default_nettype wire

[hw/rtl/vrp_checker.sv]
`default_nettype none
`include "vertex_rotate_project_unit_defines.svh"

module vrp_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         done,
    input  logic [vrp_pkg::COL_W-1:0]    pixel_col,
    input  logic [vrp_pkg::ROW_W-1:0]    pixel_row
);
    import vrp_pkg::*;

    `VRP_ASSERT_ALWAYS(a_never_busy, !busy)
    `VRP_ASSERT_IMPLIES(a_done_after_item, done, $past(start && !busy, LAT + 1))
    `VRP_ASSERT_IMPLIES(a_col_on_screen, done, pixel_col <= COL_W'(COL_LIMIT))
    `VRP_ASSERT_IMPLIES(a_row_on_screen, done, pixel_row <= ROW_W'(ROW_LIMIT))

endmodule

bind vertex_rotate_project_unit vrp_checker u_vrp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row)
);

`default_nettype wire

[tb/vertex_rotate_project_unit_tb.sv]
`timescale 1ns / 1ps

module vertex_rotate_project_unit_tb;

    import vrp_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 153;
    localparam int QUIET_PHASE    = 3;
    localparam int STALL_LIMIT    = 2000;
    localparam int IDLE_PERCENT   = 27;

    localparam logic [CFG_W-1:0] EDGE_VALUES [5] = '{16'h8000, 16'hC000, 16'h0000,
                                                     16'h4000, 16'h7FFF};

    typedef struct packed {
        logic        [COL_W-1:0]   col;
        logic        [ROW_W-1:0]   row;
        logic signed [DEPTH_W-1:0] depth;
    } pixel_t;

    class projection_book;
        longint pitch_sin;
        longint pitch_cos;
        longint yaw_sin;
        longint yaw_cos;
        pixel_t pending_pixels[$];
        int unsigned errors;

        function new();
            pitch_sin = 0;
            pitch_cos = longint'(Q_ONE);
            yaw_sin   = 0;
            yaw_cos   = longint'(Q_ONE);
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic signed [CFG_W-1:0] val);
            case (idx)
                REG_SIN_PITCH: pitch_sin = longint'(val);
                REG_COS_PITCH: pitch_cos = longint'(val);
                REG_SIN_YAW:   yaw_sin   = longint'(val);
                REG_COS_YAW:   yaw_cos   = longint'(val);
                default:       ;
            endcase
        endfunction

        function longint floor_quot(longint num, longint den);
            longint q;
            q = num / den;
            if ((num % den) != 0 && num < 0)
            begin
                q = q - 1;
            end
            return q;
        endfunction

        function void project_vertex(logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y,
                                     logic signed [COORD_W-1:0] z);
            longint y1;
            longint z1;
            longint x2;
            longint z2;
            longint den;
            longint col;
            longint row;
            pixel_t p;
            y1 = (longint'(y) * pitch_cos - longint'(z) * pitch_sin) >>> Q_FRAC;
            z1 = (longint'(y) * pitch_sin + longint'(z) * pitch_cos) >>> Q_FRAC;
            x2 = (longint'(x) * yaw_cos - z1 * yaw_sin) >>> Q_FRAC;
            z2 = (longint'(x) * yaw_sin + z1 * yaw_cos) >>> Q_FRAC;
            den = z2 + DEPTH_BIAS;
            if (den <= 0)
            begin
                den = 1;
            end
            col = floor_quot(SCREEN_WIDTH * (10 * x2 + 16 * den), 32 * den);
            row = floor_quot(SCREEN_HEIGHT * (128 * den - 100 * y1), 256 * den);
            if (col < 0)
            begin
                col = 0;
            end
            else if (col > SCREEN_WIDTH - 1)
            begin
                col = SCREEN_WIDTH - 1;
            end
            if (row < 0)
            begin
                row = 0;
            end
            else if (row > SCREEN_HEIGHT - 1)
            begin
                row = SCREEN_HEIGHT - 1;
            end
            if (z2 < DEPTH_MIN)
            begin
                z2 = DEPTH_MIN;
            end
            else if (z2 > DEPTH_MAX)
            begin
                z2 = DEPTH_MAX;
            end
            p.col   = COL_W'(col);
            p.row   = ROW_W'(row);
            p.depth = DEPTH_W'(z2);
            pending_pixels = {pending_pixels, p};
        endfunction

        function void check_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                  logic signed [DEPTH_W-1:0] depth);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("result with no vertex waiting: col %0d row %0d depth %0d",
                       col, row, depth);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (col !== want.col)
            begin
                $error("pixel_col mismatch: expected %0d, actual %0d", want.col, col);
                errors++;
            end
            if (row !== want.row)
            begin
                $error("pixel_row mismatch: expected %0d, actual %0d", want.row, row);
                errors++;
            end
            if (depth !== want.depth)
            begin
                $error("depth mismatch: expected %0d, actual %0d", want.depth, depth);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_pixels.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [COORD_W-1:0]   coord_x;
    logic signed [COORD_W-1:0]   coord_y;
    logic signed [COORD_W-1:0]   coord_z;
    logic                        cfg_wr_en;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [CFG_W-1:0]     cfg_data;
    logic                        done;
    logic        [COL_W-1:0]     pixel_col;
    logic        [ROW_W-1:0]     pixel_row;
    logic signed [DEPTH_W-1:0]   depth;

    projection_book book = new();
    bit             no_idle = 1'b0;
    int unsigned    vertices_seen = 0;
    int unsigned    results_seen = 0;
    int unsigned    reg_writes = 0;
    int unsigned    settings_used = 1;
    int unsigned    stall_cycles = 0;

    vertex_rotate_project_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .depth     (depth)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done || cfg_wr_en))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles = stall_cycles + 1;
        end
        if (rst_n)
        begin
            if (start && !busy)
            begin
                book.project_vertex(coord_x, coord_y, coord_z);
                vertices_seen++;
            end
            if (done)
            begin
                book.check_pixel(pixel_col, pixel_row, depth);
                results_seen++;
            end
            if (cfg_wr_en)
            begin
                book.set_reg(cfg_index, cfg_data);
                reg_writes++;
            end
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [CFG_W-1:0] rand_q14();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            return CFG_W'(int'($urandom_range(32768)) - 16384);
        end
        else if (pick < 80)
        begin
            return CFG_W'($urandom);
        end
        return EDGE_VALUES[$urandom_range(4)];
    endfunction

    task automatic send_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (book.pending_count() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_rotation(input logic [CFG_W-1:0] p_sin, input logic [CFG_W-1:0] p_cos,
                                 input logic [CFG_W-1:0] y_sin, input logic [CFG_W-1:0] y_cos);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SIN_PITCH;
        cfg_data  <= p_sin;
        @(posedge clk);
        cfg_index <= REG_COS_PITCH;
        cfg_data  <= p_cos;
        @(posedge clk);
        cfg_index <= REG_SIN_YAW;
        cfg_data  <= y_sin;
        @(posedge clk);
        cfg_index <= REG_COS_YAW;
        cfg_data  <= y_cos;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        coord_x   = '0;
        coord_y   = '0;
        coord_z   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity rotation straight out of reset, including points behind the eye.
        send_vertex(16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h4000, 16'h4000, 16'h4000);
        send_vertex(16'hC000, 16'hC000, 16'hC000);
        send_vertex(16'h4000, 16'hC000, 16'hC000);
        send_vertex(16'hC000, 16'h4000, 16'hC000);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h0000, 16'h0000, 16'h8000);
        send_vertex(16'h7FFF, 16'h8000, 16'h8001);
        send_vertex(16'h8000, 16'h7FFF, 16'h8001);

        load_rotation(16'h4000, 16'h0000, 16'hC000, 16'h0000);
        send_vertex(16'h4000, 16'h4000, 16'h4000);
        send_vertex(16'hC000, 16'h4000, 16'h0000);
        send_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
        send_vertex(16'h0000, 16'h8000, 16'h0000);

        // Registers beyond unity drive the depth past its range.
        load_rotation(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h4000, 16'hC000, 16'h7FFF);

        load_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_vertex(16'h8000, 16'h7FFF, 16'h0000);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                load_rotation(16'h0000, 16'h4000, 16'h0000, 16'h4000);
            end
            else
            begin
                load_rotation(rand_q14(), rand_q14(), rand_q14(), rand_q14());
            end
            no_idle = (phase == QUIET_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_vertex(rand_q14(), rand_q14(), rand_q14());
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (LAT + 6) @(posedge clk);
        if (book.pending_count() != 0)
        begin
            $error("%0d projected vertices never came out", book.pending_count());
            book.errors++;
        end
        $display("Covered %0d vertices and %0d results under %0d rotation settings,",
                 vertices_seen, results_seen, settings_used);
        $display("with %0d register writes, points behind the eye and off-screen clamping.",
                 reg_writes);
        if (book.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
